// ----- hdl/radix_heap_priority_queue_defines.svh -----
// Assertion macros shared by the checking code of the radix heap queue.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef RADIX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define RADIX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rhpq_pkg.sv -----
package rhpq_pkg;

  localparam int DEF_CAPACITY    = 64;
  localparam int DEF_KEY_WIDTH   = 32;
  localparam int DEF_NUM_BUCKETS = 33;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BELOW = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [31:0] result_key;
    logic [1:0]  status;
    logic [6:0]  entries;
  } rsp_t;

endpackage

// ----- hdl/radix_heap_priority_queue.sv -----
// Monotone radix heap priority queue. Each request word either inserts a key or removes the
// current minimum, and every request produces exactly one response word carrying the removed
// key (zero unless a delete succeeded), a status code and the number of keys held afterward.
// Keys live in CAPACITY slots held in three small memories (occupancy, bucket tag, key); all
// work is done by one sequencer that walks the slots one address per cycle, sharing a single
// bucket tag unit. An insert scans for the lowest free slot. A delete that must move to a new
// bucket makes two passes: one finds the lowest occupied bucket and its smallest key, the
// second retags the rest of that bucket; a delete from bucket 0 skips the second pass.
// Rejected requests (delete when empty, insert when full, insert below the minimum) are
// answered without a slot scan. After reset the occupancy memory is cleared, one slot per
// cycle, and stall stays high during that time. The block takes a new request while a
// finished response word is still waiting downstream.
module radix_heap_priority_queue #(
  parameter int CAPACITY    = rhpq_pkg::DEF_CAPACITY,
  parameter int KEY_WIDTH   = rhpq_pkg::DEF_KEY_WIDTH,
  parameter int NUM_BUCKETS = rhpq_pkg::DEF_NUM_BUCKETS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rhpq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output rhpq_pkg::rsp_t rsp
);

  import rhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = $clog2(NUM_BUCKETS);

  localparam logic [AW:0]   IDX_END   = (AW + 1)'(CAPACITY);
  localparam logic [AW:0]   IDX_ONE   = 1;
  localparam logic [AW-1:0] ADDR_LAST = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(CAPACITY);
  localparam logic [CW-1:0] CNT_ONE   = 1;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_INS    = 3'd2;
  localparam logic [2:0] S_FIND   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_RETAG  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]           state;
  logic [AW:0]          idx;        // next slot to read; also the clear pointer
  logic                 chk_vld;    // read data for chk_addr is present this cycle
  logic [AW-1:0]        chk_addr;
  logic [CW-1:0]        count;
  logic [KEY_WIDTH-1:0] cur_min;
  logic [KEY_WIDTH-1:0] key_r;
  logic                 have;       // a candidate minimum has been seen in the find pass
  logic [TW-1:0]        low;        // lowest occupied bucket found so far
  logic [KEY_WIDTH-1:0] best;       // smallest key in that bucket
  logic [AW-1:0]        pick;       // slot holding it
  logic [KEY_WIDTH-1:0] res_key;
  logic [1:0]           res_status;

  // Registered memory read data, valid in the cycle after the address.
  logic                 v_rd;
  logic [TW-1:0]        tag_rd;
  logic [KEY_WIDTH-1:0] key_rd;

  logic                 issue;
  logic                 chk_last;
  logic                 ins_hit;
  logic                 retag_hit;
  logic [KEY_WIDTH-1:0] tu_key;
  logic [TW-1:0]        tu_tag;

  logic                 vm_we;
  logic [AW-1:0]        vm_waddr;
  logic                 vm_wdata;

  logic [KEY_WIDTH+31:0] key_ext;
  logic [KEY_WIDTH-1:0]  key_in;
  logic [KEY_WIDTH+31:0] res_key_ext;
  logic [CW+6:0]         cnt_ext;

  // Keys are taken modulo 2**KEY_WIDTH; the response fields are cut back to their port widths.
  assign key_ext     = {{KEY_WIDTH{1'b0}}, req.key};
  assign key_in      = key_ext[KEY_WIDTH-1:0];
  assign res_key_ext = {32'd0, res_key};
  assign cnt_ext     = {7'd0, count};

  assign req_stall = (state != S_IDLE);

  // All three scanning passes read one slot per cycle and look at it in the next cycle.
  assign issue = ((state == S_INS) || (state == S_FIND) || (state == S_RETAG)) &&
                 (idx != IDX_END);
  assign chk_last  = chk_vld && (chk_addr == ADDR_LAST);
  assign ins_hit   = (state == S_INS) && chk_vld && !v_rd;
  assign retag_hit = (state == S_RETAG) && chk_vld && v_rd && (tag_rd == low);

  // The tag unit serves both the insert (new key) and the retag pass (stored key).
  assign tu_key = (state == S_INS) ? key_r : key_rd;

  rhpq_tag_unit #(
    .KEY_WIDTH   (KEY_WIDTH),
    .NUM_BUCKETS (NUM_BUCKETS),
    .TAG_W       (TW)
  ) u_tag_unit (
    .key  (tu_key),
    .base (cur_min),
    .tag  (tu_tag)
  );

  // Occupancy is written by the clearing pass, by an insert and by the removal of the minimum.
  always_comb begin
    vm_we    = 1'b0;
    vm_waddr = chk_addr;
    vm_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        vm_we    = 1'b1;
        vm_waddr = idx[AW-1:0];
      end
      S_INS: begin
        vm_we    = ins_hit;
        vm_wdata = 1'b1;
      end
      S_COMMIT: begin
        vm_we    = 1'b1;
        vm_waddr = pick;
      end
      default: begin
        vm_we = 1'b0;
      end
    endcase
  end

  rhpq_ram #(
    .WIDTH (1),
    .DEPTH (CAPACITY)
  ) u_valid_mem (
    .clk   (clk),
    .we    (vm_we),
    .waddr (vm_waddr),
    .wdata (vm_wdata),
    .raddr (idx[AW-1:0]),
    .rdata (v_rd)
  );

  rhpq_ram #(
    .WIDTH (TW),
    .DEPTH (CAPACITY)
  ) u_tag_mem (
    .clk   (clk),
    .we    (ins_hit || retag_hit),
    .waddr (chk_addr),
    .wdata (tu_tag),
    .raddr (idx[AW-1:0]),
    .rdata (tag_rd)
  );

  rhpq_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (CAPACITY)
  ) u_key_mem (
    .clk   (clk),
    .we    (ins_hit),
    .waddr (chk_addr),
    .wdata (key_r),
    .raddr (idx[AW-1:0]),
    .rdata (key_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      chk_vld   <= 1'b0;
      count     <= '0;
      cur_min   <= '0;
      have      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // The read pipeline only runs in the scanning states, so it is idle in all others.
      chk_vld  <= issue;
      chk_addr <= idx[AW-1:0];
      if (issue) begin
        idx <= idx + IDX_ONE;
      end
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          if (idx[AW-1:0] == ADDR_LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + IDX_ONE;
          end
        end

        S_IDLE: begin
          if (req_valid) begin
            key_r      <= key_in;
            idx        <= '0;
            have       <= 1'b0;
            res_key    <= '0;
            res_status <= ST_OK;
            if (req.op == OP_INSERT) begin
              if (count == CNT_FULL) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else if (count == '0) begin
                // The first key of an empty heap becomes the minimum.
                cur_min <= key_in;
                state   <= S_INS;
              end else if (key_in < cur_min) begin
                res_status <= ST_BELOW;
                state      <= S_DONE;
              end else begin
                state <= S_INS;
              end
            end else begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_DONE;
              end else begin
                state <= S_FIND;
              end
            end
          end
        end

        S_INS: begin
          // A free slot always exists here, since a full heap was rejected.
          if (ins_hit) begin
            count <= count + CNT_ONE;
            state <= S_DONE;
          end
        end

        S_FIND: begin
          // Lowest occupied bucket and its smallest key, in one pass; ties keep the lower slot.
          if (chk_vld && v_rd) begin
            if (!have || (tag_rd < low)) begin
              have <= 1'b1;
              low  <= tag_rd;
              best <= key_rd;
              pick <= chk_addr;
            end else if ((tag_rd == low) && (key_rd < best)) begin
              best <= key_rd;
              pick <= chk_addr;
            end
          end
          if (chk_last) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          count   <= count - CNT_ONE;
          res_key <= best;
          idx     <= '0;
          if (low != '0) begin
            cur_min <= best;
            state   <= S_RETAG;
          end else begin
            state <= S_DONE;
          end
        end

        S_RETAG: begin
          if (chk_last) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid      <= 1'b1;
            rsp.result_key <= res_key_ext[31:0];
            rsp.status     <= res_status;
            rsp.entries    <= cnt_ext[6:0];
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/rhpq_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
module rhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rhpq_tag_unit.sv -----
// Bucket tag: bit length of key XOR base, saturated to the last bucket.
// The highest set bit is found by a binary search over halves of the word.
module rhpq_tag_unit #(
  parameter int KEY_WIDTH   = 32,
  parameter int NUM_BUCKETS = 33,
  parameter int TAG_W       = 6
) (
  input  logic [KEY_WIDTH-1:0] key,
  input  logic [KEY_WIDTH-1:0] base,
  output logic [TAG_W-1:0]     tag
);

  localparam int LV = $clog2(KEY_WIDTH);
  localparam int PW = 1 << LV;
  localparam logic [LV:0] LEN_ONE = 1;

  logic [PW-1:0]       win;
  logic [LV-1:0]       pos;
  logic [LV:0]         len;
  logic [LV+TAG_W:0]   len_ext;

  always_comb begin
    win = PW'(key ^ base);
    pos = '0;
    for (int l = LV - 1; l >= 0; l--) begin
      if ((win >> (1 << l)) != '0) begin
        win    = win >> (1 << l);
        pos[l] = 1'b1;
      end
    end
    len     = (key != base) ? ({1'b0, pos} + LEN_ONE) : '0;
    len_ext = {{TAG_W{1'b0}}, len};
    if (int'(len) > NUM_BUCKETS - 1) begin
      tag = TAG_W'(NUM_BUCKETS - 1);
    end else begin
      tag = len_ext[TAG_W-1:0];
    end
  end

endmodule

// ----- hdl/rhpq_checker.sv -----
`include "radix_heap_priority_queue_defines.svh"

// Port-level checks for the radix heap queue.
module rhpq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input rhpq_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input rhpq_pkg::rsp_t rsp
);

  import rhpq_pkg::*;

  // A response word that is held back keeps its value.
  `RHPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response word changed while stalled")

  // One request is worked on at a time.
  `RHPQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken while another is in work")

  // A delete on an empty heap leaves it empty and returns no key.
  `RHPQ_ASSERT_NOW(a_empty_word, rsp_valid && (rsp.status == ST_EMPTY), (rsp.result_key == '0) && (rsp.entries == '0), "empty status with key or entries")

  // Rejected inserts return no key.
  `RHPQ_ASSERT_NOW(a_reject_key, rsp_valid && ((rsp.status == ST_FULL) || (rsp.status == ST_BELOW)), rsp.result_key == '0, "rejected insert returned a key")

endmodule

bind radix_heap_priority_queue rhpq_checker u_rhpq_checker (.*);
